### hw/rtl/gbdt_pkg.sv
// ----------------------------------------------------------------------------
// gbdt_pkg
// Shared types and constants for the grid bit domain table: operation codes,
// controller states, and the command and status bundles between the
// controller and the datapath.
// ----------------------------------------------------------------------------
package gbdt_pkg;

    // Default largest domain size (values per cell, rows and columns).
    localparam int MAX_SIZE_DEF = 16;

    // Width used for sizes, counts and member positions inside the datapath.
    // It holds any domain size up to 64 as well as the 5-bit register value.
    localparam int SIZE_W = 7;

    // Field widths fixed by the stream format.
    localparam int CFG_W    = 5;
    localparam int OP_W     = 3;
    localparam int POS_W    = 4;
    localparam int FIELD_W  = 5;
    localparam int IN_W     = 16;
    localparam int OUT_W    = 24;
    localparam int OUT_USED = 18;

    localparam logic [CFG_W-1:0]   DOMAIN_SIZE_RST = 5'd16;
    localparam logic [FIELD_W-1:0] NONE_VALUE      = 5'h1f;

    typedef enum logic [OP_W-1:0] {
        OP_QUERY     = 3'd0,
        OP_ADD       = 3'd1,
        OP_REMOVE    = 3'd2,
        OP_FILL      = 3'd3,
        OP_EMPTY     = 3'd4,
        OP_FILL_ALL  = 3'd5,
        OP_EMPTY_ALL = 3'd6
    } op_t;

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_READ,
        ST_WRITE,
        ST_SWEEP,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic capture;
        logic mem_rd;
        logic mem_wr;
        logic sweep_wr;
        logic load_out;
    } cmd_t;

    typedef struct packed {
        logic in_sweep;
        logic in_bad;
        logic sweep_last;
        logic out_free;
    } status_t;

endpackage

### hw/rtl/grid_bit_domain_table.sv
// ----------------------------------------------------------------------------
// grid_bit_domain_table
// Table of constraint-solver domains, one bit set per grid cell, with
// add, remove, fill, empty, fill-all, empty-all and query operations.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Handshake            Contents
//  s_*       in         s_tvalid / s_tready  operation, row, col, element
//  m_*       out        m_tvalid / m_tready  count, lowest, single, flags
//  cfg_*     in         cfg_wen              domain_size
//
// A cell operation or query steps through accept, memory read, then write-back and result.
// A cell beat with an index out of range leaves the store untouched; fill-all and empty-all still sweep.
// Fill-all and empty-all write one cell per cycle across the whole store, then hand off the result.
// After reset a clearing pass empties every cell; s_tready is low until it is done.
// A finished result waits in the output register while the next beat is taken and processed;
// only the hand-off of the following result stalls on m_tready.
//
module grid_bit_domain_table #(
    parameter int MAX_SIZE = gbdt_pkg::MAX_SIZE_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    // Register write: domain_size.
    input  logic                        cfg_wen,
    input  logic [gbdt_pkg::CFG_W-1:0]  cfg_wdata,
    // Input beats.
    input  logic                        s_tvalid,
    output logic                        s_tready,
    // Fields from bit 0: operation[2:0], row[6:3], col[10:7], element[14:11], pad.
    input  logic [gbdt_pkg::IN_W-1:0]   s_tdata,
    // Result beats.
    output logic                        m_tvalid,
    input  logic                        m_tready,
    // Fields from bit 0: count[4:0], lowest[9:5], single_value[14:10],
    // is_member[15], is_empty[16], bad_index[17], zero pad.
    output logic [gbdt_pkg::OUT_W-1:0]  m_tdata
);

    // Commands from the controller and status back from the datapath.
    gbdt_pkg::cmd_t    cmd;
    gbdt_pkg::status_t status;

    gbdt_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    gbdt_dp #(
        .MAX_SIZE (MAX_SIZE)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wen   (cfg_wen),
        .cfg_wdata (cfg_wdata),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cmd       (cmd),
        .status    (status)
    );

endmodule

### hw/rtl/gbdt_ctrl.sv
// ----------------------------------------------------------------------------
// gbdt_ctrl
// Controller state machine: sequences the clearing pass, cell
// read-modify-write, whole-store sweeps and the hand-off of each result.
// ----------------------------------------------------------------------------
module gbdt_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  gbdt_pkg::status_t  status,
    output gbdt_pkg::cmd_t     cmd
);

    gbdt_pkg::state_t state_reg;
    gbdt_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= gbdt_pkg::ST_INIT;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        case (state_reg)
            gbdt_pkg::ST_INIT:
            begin
                // Clearing pass: every cell is written empty once.
                cmd.sweep_wr = 1'b1;
                if (status.sweep_last)
                begin
                    state_next = gbdt_pkg::ST_IDLE;
                end
            end
            gbdt_pkg::ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.capture = 1'b1;
                    if (status.in_sweep)
                    begin
                        state_next = gbdt_pkg::ST_SWEEP;
                    end
                    else if (status.in_bad)
                    begin
                        state_next = gbdt_pkg::ST_FINISH;
                    end
                    else
                    begin
                        state_next = gbdt_pkg::ST_READ;
                    end
                end
            end
            gbdt_pkg::ST_READ:
            begin
                cmd.mem_rd = 1'b1;
                state_next = gbdt_pkg::ST_WRITE;
            end
            gbdt_pkg::ST_WRITE:
            begin
                // The write is repeated while the result waits; it is idempotent.
                cmd.mem_wr = 1'b1;
                if (status.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = gbdt_pkg::ST_IDLE;
                end
            end
            gbdt_pkg::ST_SWEEP:
            begin
                cmd.sweep_wr = 1'b1;
                if (status.sweep_last)
                begin
                    state_next = gbdt_pkg::ST_FINISH;
                end
            end
            gbdt_pkg::ST_FINISH:
            begin
                if (status.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = gbdt_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = gbdt_pkg::ST_IDLE;
            end
        endcase
    end

    a_load_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |-> status.out_free)
        else $error("result loaded while the output register is occupied");

    a_read_then_write: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == gbdt_pkg::ST_READ |=> state_reg == gbdt_pkg::ST_WRITE)
        else $error("cell read not followed by its write-back");

    a_sweep_ends_in_result: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == gbdt_pkg::ST_SWEEP && status.sweep_last)
            |=> state_reg == gbdt_pkg::ST_FINISH)
        else $error("sweep finished without producing its result");

    a_one_write_port: assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.mem_wr && cmd.sweep_wr) && !(cmd.mem_rd && cmd.sweep_wr))
        else $error("two accesses requested on the single memory port");

endmodule

### hw/rtl/gbdt_dp.sv
// ----------------------------------------------------------------------------
// gbdt_dp
// Datapath: size register, captured beat, the cell memory with its sweep
// counter, the modify logic, result encoding and the output register.
// ----------------------------------------------------------------------------
module gbdt_dp #(
    parameter int MAX_SIZE = gbdt_pkg::MAX_SIZE_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_wen,
    input  logic [gbdt_pkg::CFG_W-1:0]  cfg_wdata,
    input  logic [gbdt_pkg::IN_W-1:0]   s_tdata,
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [gbdt_pkg::OUT_W-1:0]  m_tdata,
    input  gbdt_pkg::cmd_t              cmd,
    output gbdt_pkg::status_t           status
);

    localparam int CELLS = MAX_SIZE * MAX_SIZE;
    localparam int IDX_W = $clog2(CELLS);
    localparam int SW    = gbdt_pkg::SIZE_W;
    localparam int FW    = gbdt_pkg::FIELD_W;
    localparam int PW    = gbdt_pkg::POS_W;

    function automatic logic [SW-1:0] pop_count(input logic [MAX_SIZE-1:0] b);
        logic [SW-1:0] n;
        n = '0;
        for (int i = 0; i < MAX_SIZE; i++)
        begin
            n = n + SW'(b[i]);
        end
        return n;
    endfunction

    // Lowest set position, all ones when the word is empty.
    function automatic logic [SW-1:0] lowest_set(input logic [MAX_SIZE-1:0] b);
        logic [SW-1:0] p;
        p = '1;
        for (int i = MAX_SIZE - 1; i >= 0; i--)
        begin
            if (b[i])
            begin
                p = SW'(i);
            end
        end
        return p;
    endfunction

    logic [gbdt_pkg::CFG_W-1:0] size_reg;
    gbdt_pkg::op_t              op_reg;
    logic [PW-1:0]              row_reg;
    logic [PW-1:0]              col_reg;
    logic [PW-1:0]              el_reg;
    logic                       bad_reg;
    logic [IDX_W-1:0]           sweep_cnt_reg;
    logic [MAX_SIZE-1:0]        rdata_reg;
    logic                       out_valid_reg;
    logic [gbdt_pkg::OUT_W-1:0] out_data_reg;

    logic [MAX_SIZE-1:0] mem [CELLS];

    logic [SW-1:0]       size_eff;
    logic [MAX_SIZE-1:0] full_mask;
    gbdt_pkg::op_t       in_op;
    logic [PW-1:0]       in_row;
    logic [PW-1:0]       in_col;
    logic [PW-1:0]       in_el;
    logic                in_cell_ok;
    logic                in_el_ok;
    logic                in_needs_el;
    logic                is_sweep;
    logic [IDX_W-1:0]    cell_idx;
    logic [MAX_SIZE-1:0] el_bit;
    logic [MAX_SIZE-1:0] new_bits;
    logic [MAX_SIZE-1:0] sweep_val;
    logic [MAX_SIZE-1:0] res_bits;
    logic [SW-1:0]       res_count;
    logic [SW-1:0]       res_low;
    logic                res_empty;
    logic                res_member;
    logic [FW-1:0]       res_single;
    logic [gbdt_pkg::OUT_W-1:0] res_data;

    // Effective size: the register value held to the range 1 to MAX_SIZE.
    always_comb
    begin
        if (size_reg == '0)
        begin
            size_eff = SW'(1);
        end
        else if (SW'(size_reg) > SW'(MAX_SIZE))
        begin
            size_eff = SW'(MAX_SIZE);
        end
        else
        begin
            size_eff = SW'(size_reg);
        end
        for (int i = 0; i < MAX_SIZE; i++)
        begin
            full_mask[i] = SW'(i) < size_eff;
        end
    end

    assign in_op       = gbdt_pkg::op_t'(s_tdata[gbdt_pkg::OP_W-1:0]);
    assign in_row      = s_tdata[gbdt_pkg::OP_W +: PW];
    assign in_col      = s_tdata[gbdt_pkg::OP_W + PW +: PW];
    assign in_el       = s_tdata[gbdt_pkg::OP_W + 2 * PW +: PW];
    assign in_cell_ok  = (SW'(in_row) < size_eff) && (SW'(in_col) < size_eff);
    assign in_el_ok    = SW'(in_el) < size_eff;
    assign in_needs_el = !(in_op == gbdt_pkg::OP_FILL || in_op == gbdt_pkg::OP_EMPTY ||
                           in_op == gbdt_pkg::OP_FILL_ALL ||
                           in_op == gbdt_pkg::OP_EMPTY_ALL);

    assign status.in_sweep   = in_op == gbdt_pkg::OP_FILL_ALL ||
                               in_op == gbdt_pkg::OP_EMPTY_ALL;
    assign status.in_bad     = !in_cell_ok || (in_needs_el && !in_el_ok);
    assign status.sweep_last = sweep_cnt_reg == IDX_W'(CELLS - 1);
    assign status.out_free   = !out_valid_reg || m_tready;

    assign is_sweep  = op_reg == gbdt_pkg::OP_FILL_ALL || op_reg == gbdt_pkg::OP_EMPTY_ALL;
    assign cell_idx  = IDX_W'(row_reg * MAX_SIZE + col_reg);
    assign el_bit    = {{(MAX_SIZE - 1){1'b0}}, 1'b1} << el_reg;
    assign sweep_val = (op_reg == gbdt_pkg::OP_FILL_ALL) ? full_mask : '0;

    always_comb
    begin
        case (op_reg)
            gbdt_pkg::OP_ADD:    new_bits = rdata_reg | el_bit;
            gbdt_pkg::OP_REMOVE: new_bits = rdata_reg & ~el_bit;
            gbdt_pkg::OP_FILL:   new_bits = full_mask;
            gbdt_pkg::OP_EMPTY:  new_bits = '0;
            default:             new_bits = rdata_reg;
        endcase
    end

    // Result encoding from the cell contents after the operation.
    assign res_bits   = is_sweep ? sweep_val : new_bits;
    assign res_count  = pop_count(res_bits);
    assign res_low    = lowest_set(res_bits);
    assign res_empty  = res_count == '0;
    assign res_member = !res_empty && (SW'(el_reg) < size_eff) && res_bits[el_reg];
    assign res_single = (res_count == SW'(1)) ? res_low[FW-1:0] : gbdt_pkg::NONE_VALUE;

    always_comb
    begin
        res_data = '0;
        if (bad_reg)
        begin
            res_data[gbdt_pkg::OUT_USED-1:0] = {1'b1, 1'b1, 1'b0, gbdt_pkg::NONE_VALUE,
                                                gbdt_pkg::NONE_VALUE, {FW{1'b0}}};
        end
        else
        begin
            res_data[gbdt_pkg::OUT_USED-1:0] = {1'b0, res_empty, res_member, res_single,
                                                res_low[FW-1:0], res_count[FW-1:0]};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_reg      <= gbdt_pkg::DOMAIN_SIZE_RST;
            op_reg        <= gbdt_pkg::OP_QUERY;
            bad_reg       <= 1'b0;
            sweep_cnt_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wen)
            begin
                size_reg <= cfg_wdata;
            end
            if (cmd.capture)
            begin
                op_reg  <= in_op;
                bad_reg <= status.in_bad;
            end
            if (cmd.sweep_wr)
            begin
                sweep_cnt_reg <= sweep_cnt_reg + 1'b1;
            end
            if (cmd.load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            row_reg <= in_row;
            col_reg <= in_col;
            el_reg  <= in_el;
        end
        if (cmd.load_out)
        begin
            out_data_reg <= res_data;
        end
    end

    // Single-port cell memory with registered read data.
    always_ff @(posedge clk)
    begin
        if (cmd.sweep_wr)
        begin
            mem[sweep_cnt_reg] <= sweep_val;
        end
        else if (cmd.mem_wr)
        begin
            mem[cell_idx] <= new_bits;
        end
        if (cmd.mem_rd)
        begin
            rdata_reg <= mem[cell_idx];
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

### sim/grid_bit_domain_table_check.sv
// ----------------------------------------------------------------------------
// grid_bit_domain_table_check
// Watches the input, result and register channels of the domain table, keeps
// its own copy of every cell, predicts one result per input beat and compares
// each result beat against the oldest prediction.
// ----------------------------------------------------------------------------
module grid_bit_domain_table_check
    import gbdt_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_wen,
    input  logic [CFG_W-1:0]  cfg_wdata,
    input  logic              s_tvalid,
    input  logic              s_tready,
    input  logic [IN_W-1:0]   s_tdata,
    input  logic              m_tvalid,
    input  logic              m_tready,
    input  logic [OUT_W-1:0]  m_tdata,
    output int                fail_count,
    output int                pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CELLS = MAX_SIZE_DEF * MAX_SIZE_DEF;

    // Result layout, count in the lowest bits.
    typedef struct packed {
        logic [OUT_W-OUT_USED-1:0] pad;
        logic                      bad_index;
        logic                      is_empty;
        logic                      is_member;
        logic [FIELD_W-1:0]        single_value;
        logic [FIELD_W-1:0]        lowest;
        logic [FIELD_W-1:0]        count;
    } cell_report_t;

    logic [MAX_SIZE_DEF-1:0] cell_bits [CELLS];
    logic [CFG_W-1:0]        size_reg;
    cell_report_t            due_reports [$];

    function automatic int active_size();
        if (size_reg == '0)
            return 1;
        if (size_reg > MAX_SIZE_DEF)
            return MAX_SIZE_DEF;
        return int'(size_reg);
    endfunction

    function automatic logic [MAX_SIZE_DEF-1:0] fill_mask(input int s);
        logic [MAX_SIZE_DEF-1:0] m;
        m = '0;
        for (int i = 0; i < s; i++)
            m[i] = 1'b1;
        return m;
    endfunction

    // Applies one beat to the cell copy and returns the report for the cell.
    function automatic cell_report_t apply_domain_op(input logic [IN_W-1:0] beat);
        op_t                     op;
        int                      row, col, el, s, idx, members, low;
        logic                    cell_ok, el_ok, bad;
        logic [MAX_SIZE_DEF-1:0] bits;
        cell_report_t            r;

        op      = (beat[2:0] == 3'd7) ? OP_QUERY : op_t'(beat[2:0]);
        row     = int'(beat[6:3]);
        col     = int'(beat[10:7]);
        el      = int'(beat[14:11]);
        s       = active_size();
        cell_ok = (row < s) && (col < s);
        el_ok   = el < s;
        if (op == OP_QUERY || op == OP_ADD || op == OP_REMOVE)
            bad = !(cell_ok && el_ok);
        else
            bad = !cell_ok;
        idx = row * MAX_SIZE_DEF + col;

        if (op == OP_FILL_ALL || op == OP_EMPTY_ALL)
        begin
            bits = (op == OP_FILL_ALL) ? fill_mask(s) : '0;
            foreach (cell_bits[i])
                cell_bits[i] = bits;
        end
        else if (!bad)
        begin
            case (op)
                OP_ADD:    cell_bits[idx][el] = 1'b1;
                OP_REMOVE: cell_bits[idx][el] = 1'b0;
                OP_FILL:   cell_bits[idx] = fill_mask(s);
                OP_EMPTY:  cell_bits[idx] = '0;
                default:   ;
            endcase
        end

        r              = '0;
        r.lowest       = NONE_VALUE;
        r.single_value = NONE_VALUE;
        r.is_empty     = 1'b1;
        r.bad_index    = bad;
        if (!bad)
        begin
            bits    = cell_bits[idx];
            members = $countones(bits);
            low     = -1;
            for (int i = MAX_SIZE_DEF - 1; i >= 0; i--)
                if (bits[i])
                    low = i;
            r.count        = FIELD_W'(members);
            r.lowest       = FIELD_W'(low);
            r.is_empty     = (members == 0);
            r.single_value = (members == 1) ? FIELD_W'(low) : NONE_VALUE;
            r.is_member    = (members != 0) && el_ok && bits[el];
        end
        return r;
    endfunction

    task automatic flag_report(input string what, input cell_report_t want,
                               input cell_report_t got, input logic have_want);
        fail_count++;
        if (fail_count <= 10)
        begin
            if (have_want)
                $display("%0t: %s: count %0d/%0d lowest %0d/%0d single %0d/%0d",
                         $time, what, want.count, got.count,
                         $signed(want.lowest), $signed(got.lowest),
                         $signed(want.single_value), $signed(got.single_value),
                         "  member %0b/%0b empty %0b/%0b bad %0b/%0b pad %0h/%0h",
                         want.is_member, got.is_member, want.is_empty, got.is_empty,
                         want.bad_index, got.bad_index, want.pad, got.pad,
                         "  (expected/actual)");
            else
                $display("%0t: %s: count %0d lowest %0d single %0d member %0b",
                         $time, what, got.count, $signed(got.lowest),
                         $signed(got.single_value), got.is_member,
                         " empty %0b bad %0b", got.is_empty, got.bad_index);
        end
    endtask

    // A result beat taken at an edge belongs to an earlier input beat, so it
    // is checked before the input beat of the same edge is predicted.
    always @(posedge clk or negedge rst_n)
    begin
        cell_report_t got, want, fresh;
        if (!rst_n)
        begin
            size_reg = DOMAIN_SIZE_RST;
            foreach (cell_bits[i])
                cell_bits[i] = '0;
            due_reports.delete();
            pending = 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                got = m_tdata;
                if (due_reports.size() == 0)
                    flag_report("result beat with nothing expected", got, got, 1'b0);
                else
                begin
                    want = due_reports.pop_front();
                    if (got !== want)
                        flag_report("result mismatch", want, got, 1'b1);
                end
            end
            if (s_tvalid && s_tready)
            begin
                fresh       = apply_domain_op(s_tdata);
                due_reports = {due_reports, fresh};
            end
            if (cfg_wen)
                size_reg = cfg_wdata;
            pending = due_reports.size();
        end
    end

endmodule

### sim/grid_bit_domain_table_tb.sv
// ----------------------------------------------------------------------------
// grid_bit_domain_table_tb
// Drives the domain table with a directed sequence and then random beats under
// four flow-control regimes, changes the domain size between batches while the
// table is idle, and takes the verdict from the checker's failure count.
// ----------------------------------------------------------------------------
module grid_bit_domain_table_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import gbdt_pkg::*;

    // The code left unused by the operation set; the table treats it as a query.
    localparam logic [OP_W-1:0] OP_SPARE = 3'd7;

    logic              clk;
    logic              rst_n;
    logic              cfg_wen   = 1'b0;
    logic [CFG_W-1:0]  cfg_wdata = '0;
    logic              s_tvalid  = 1'b0;
    logic              s_tready;
    logic [IN_W-1:0]   s_tdata   = '0;
    logic              m_tvalid;
    logic              m_tready  = 1'b0;
    logic [OUT_W-1:0]  m_tdata;
    int                fail_count;
    int                pending;

    // Flow-control knobs, in percent per cycle.
    int                idle_pct  = 0;
    int                stall_pct = 0;
    // Remaining beats or cycles of a stretch where the knobs are ignored.
    int                send_burst  = 0;
    int                ready_burst = 0;
    // Effective domain size as last written; only used to shape the stimulus.
    int                live_size = 16;

    grid_bit_domain_table u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wen   (cfg_wen),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    grid_bit_domain_table_check u_check (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_wen    (cfg_wen),
        .cfg_wdata  (cfg_wdata),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .fail_count (fail_count),
        .pending    (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Hard stop. The slowest legal run, including the clearing pass after
    // reset, every sweep and the heaviest stalls, stays far below this.
    initial
    begin
        #5_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    // Result side: stall with the current probability, with occasional
    // stretches of steady acceptance so that back-to-back hand-offs happen too.
    always @(negedge clk)
    begin
        if (ready_burst > 0)
        begin
            ready_burst--;
            m_tready <= 1'b1;
        end
        else if ($urandom_range(99) < 2)
        begin
            ready_burst = 24;
            m_tready <= 1'b1;
        end
        else
            m_tready <= ($urandom_range(99) >= stall_pct);
    end

    // Presents one beat and returns at the falling edge after it was taken.
    // The caller is always at a falling edge, so s_tvalid gets one update per
    // step: low during a gap, or straight from one beat to the next.
    task automatic send_beat(input logic [OP_W-1:0] code, input int row, input int col,
                             input int el);
        if (send_burst > 0)
            send_burst--;
        else if ($urandom_range(99) < 3)
            send_burst = 20;
        if (send_burst == 0)
            while ($urandom_range(99) < idle_pct)
            begin
                s_tvalid <= 1'b0;
                @(negedge clk);
            end
        s_tvalid <= 1'b1;
        s_tdata  <= {1'b0, el[3:0], col[3:0], row[3:0], code};
        do
            @(posedge clk);
        while (!s_tready);
        @(negedge clk);
    endtask

    // Waits until every result is in and the table has gone quiet, then
    // writes a new domain size. This is also the point where the sender
    // holds off until nothing is outstanding.
    task automatic drain_then_resize(input logic [CFG_W-1:0] value);
        s_tvalid <= 1'b0;
        wait (pending == 0);
        repeat (8) @(negedge clk);
        cfg_wen   <= 1'b1;
        cfg_wdata <= value;
        @(negedge clk);
        cfg_wen   <= 1'b0;
        if (value == '0)
            live_size = 1;
        else if (value > MAX_SIZE_DEF)
            live_size = MAX_SIZE_DEF;
        else
            live_size = int'(value);
    endtask

    // Mostly in range for the current size, sometimes anywhere in the field
    // so that out-of-range indexes and every bit pattern show up.
    function automatic int pick_index();
        if ($urandom_range(99) < 88)
            return $urandom_range(live_size - 1);
        return $urandom_range(15);
    endfunction

    task automatic send_random();
        int              pick, row, col, el;
        logic [OP_W-1:0] code;

        pick = $urandom_range(99);
        if (pick < 24)
            code = OP_QUERY;
        else if (pick < 48)
            code = OP_ADD;
        else if (pick < 64)
            code = OP_REMOVE;
        else if (pick < 72)
            code = OP_FILL;
        else if (pick < 80)
            code = OP_EMPTY;
        else if (pick < 83)
            code = OP_FILL_ALL;
        else if (pick < 86)
            code = OP_EMPTY_ALL;
        else if (pick < 92)
            code = OP_SPARE;
        else
            code = OP_W'($urandom_range(7));

        // Half of the beats hit the corner cells so that adds and removes pile
        // up on the same domains: full cells, single members, emptied cells.
        if ($urandom_range(1))
        begin
            row = $urandom_range(1) ? 0 : live_size - 1;
            col = $urandom_range(1) ? 0 : live_size - 1;
        end
        else
        begin
            row = pick_index();
            col = pick_index();
        end
        el = pick_index();
        send_beat(code, row, col, el);
    endtask

    // One flow-control regime: batches of random beats, with a size change
    // between batches. Extremes, including the clamped codes 0 and 31, are
    // picked often.
    task automatic random_phase(input int idle, input int stall, input int beats);
        int chunk;
        int sel;
        logic [CFG_W-1:0] next_size;

        idle_pct  = idle;
        stall_pct = stall;
        while (beats > 0)
        begin
            sel = $urandom_range(9);
            case (sel)
                0:       next_size = 5'd0;
                1:       next_size = 5'd1;
                2:       next_size = 5'd2;
                3:       next_size = 5'd16;
                4:       next_size = 5'd31;
                default: next_size = CFG_W'($urandom_range(31));
            endcase
            drain_then_resize(next_size);
            chunk = $urandom_range(30, 70);
            if (chunk > beats)
                chunk = beats;
            repeat (chunk) send_random();
            beats -= chunk;
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed part at the reset size of 16. The first beat waits out the
        // clearing pass, since s_tready stays low until it is done.
        send_beat(OP_QUERY, 0, 0, 0);          // untouched store reads empty
        send_beat(OP_ADD, 15, 15, 15);         // highest cell, highest value
        send_beat(OP_ADD, 15, 15, 0);          // new lowest member
        send_beat(OP_REMOVE, 15, 15, 0);       // back to a single member
        send_beat(OP_QUERY, 15, 15, 15);
        send_beat(OP_FILL, 3, 4, 0);
        send_beat(OP_REMOVE, 3, 4, 0);         // lowest moves up to 1
        send_beat(OP_EMPTY, 3, 4, 0);
        send_beat(OP_SPARE, 15, 15, 15);       // unused code behaves as a query
        send_beat(OP_FILL_ALL, 2, 2, 0);
        send_beat(OP_QUERY, 9, 9, 8);
        send_beat(OP_EMPTY_ALL, 0, 0, 0);
        send_beat(OP_QUERY, 9, 9, 8);

        // Small domain: every index check, and sweeps with a bad address.
        drain_then_resize(5'd4);
        send_beat(OP_ADD, 4, 0, 0);            // row out of range
        send_beat(OP_QUERY, 0, 0, 5);          // element out of range
        send_beat(OP_FILL, 0, 7, 0);           // column out of range
        send_beat(OP_EMPTY, 3, 3, 15);         // element is not checked here
        send_beat(OP_FILL, 1, 1, 0);
        send_beat(OP_REMOVE, 1, 1, 0);
        send_beat(OP_FILL_ALL, 5, 0, 0);       // sweeps, but reports bad index
        send_beat(OP_QUERY, 2, 2, 3);
        send_beat(OP_EMPTY_ALL, 15, 15, 15);

        // Members above a later, smaller size stay stored and still count.
        drain_then_resize(5'd16);
        send_beat(OP_ADD, 0, 0, 15);
        send_beat(OP_ADD, 0, 0, 9);
        drain_then_resize(5'd2);
        send_beat(OP_QUERY, 0, 0, 1);
        drain_then_resize(5'd0);               // clamps to a size of one
        send_beat(OP_ADD, 0, 0, 0);
        send_beat(OP_QUERY, 1, 0, 0);
        drain_then_resize(5'd31);              // clamps to the largest size
        send_beat(OP_QUERY, 0, 0, 15);

        // Random part under the four flow-control regimes.
        random_phase(0, 0, 262);
        random_phase(82, 0, 262);
        random_phase(0, 82, 262);
        random_phase(24, 24, 264);

        s_tvalid <= 1'b0;
        wait (pending == 0);
        repeat (10) @(posedge clk);
        if (fail_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
